// ===== rtl/lvc_pkg.sv =====
// Shared widths, latencies and constants for the line viewport clipper.
`timescale 1ns / 1ps
`default_nettype none

package lvc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QW        = 32;
    localparam int WW        = 64;
    localparam int IN_W      = 4 * QW;
    localparam int OUT_W     = 6 * QW;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;
    localparam int NZL_W     = 16;

    localparam int DIV_STEPS = WW;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    localparam logic [QW-1:0] Q_HALF   = QW'(64'd1 << (FRAC_BITS - 1));
    localparam logic [QW-1:0] VIEW_RST = QW'(64'd10 << FRAC_BITS);

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_TOP    = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_BOTTOM = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] REG_LEFT   = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] REG_RIGHT  = CFG_AW'(3);
    localparam logic [CFG_AW-1:0] REG_NZL    = CFG_AW'(4);

endpackage

`default_nettype wire

// ===== rtl/lvc_div.sv =====
// Pipelined signed divider, one quotient bit per stage, saturated 32-bit quotient.
`timescale 1ns / 1ps
`default_nettype none

module lvc_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic signed [lvc_pkg::WW-1:0]   i_num,
    input  wire logic signed [lvc_pkg::QW-1:0]   i_den,
    output logic signed [lvc_pkg::QW-1:0]        o_quo
);

    localparam int QW = lvc_pkg::QW;
    localparam int WW = lvc_pkg::WW;
    localparam int NS = lvc_pkg::DIV_STEPS;

    logic [WW-1:0] r_num [0:NS-1];
    logic [QW-1:0] r_rem [0:NS-1];
    logic [QW-1:0] r_den [0:NS-1];
    logic [QW-1:0] r_q   [0:NS];
    logic          r_ovf [0:NS];
    logic          r_neg [0:NS];
    logic signed [QW-1:0] r_quo;

    logic [QW:0]   w_sh  [0:NS-1];
    logic [QW:0]   w_tr  [0:NS-1];
    logic [QW-1:0] n_rem [0:NS-1];
    logic [QW-1:0] n_q   [0:NS-1];
    logic          n_ovf [0:NS-1];
    logic signed [QW-1:0] n_quo;

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            w_sh[k] = {r_rem[k], r_num[k][WW-1]};
            w_tr[k] = w_sh[k] - {1'b0, r_den[k]};
            n_rem[k] = w_tr[k][QW] ? w_sh[k][QW-1:0] : w_tr[k][QW-1:0];
            n_q[k]   = {r_q[k][QW-2:0], ~w_tr[k][QW]};
            n_ovf[k] = r_ovf[k] | r_q[k][QW-1];
        end
    end

    always_comb begin
        if (r_neg[NS]) begin
            if (r_ovf[NS] || (r_q[NS][QW-1] && (|r_q[NS][QW-2:0]))) begin
                n_quo = {1'b1, {(QW-1){1'b0}}};
            end else begin
                n_quo = -$signed(r_q[NS]);
            end
        end else begin
            if (r_ovf[NS] || r_q[NS][QW-1]) begin
                n_quo = {1'b0, {(QW-1){1'b1}}};
            end else begin
                n_quo = $signed(r_q[NS]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= i_num[WW-1] ? WW'(-i_num) : WW'(i_num);
            r_den[0] <= i_den[QW-1] ? QW'(-i_den) : QW'(i_den);
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_ovf[0] <= 1'b0;
            r_neg[0] <= i_num[WW-1] ^ i_den[QW-1];
            for (int k = 0; k < NS; k++) begin
                r_q[k+1]   <= n_q[k];
                r_ovf[k+1] <= n_ovf[k];
                r_neg[k+1] <= r_neg[k];
            end
            for (int k = 0; k < NS - 1; k++) begin
                r_num[k+1] <= r_num[k] << 1;
                r_rem[k+1] <= n_rem[k];
                r_den[k+1] <= r_den[k];
            end
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

`default_nettype wire

// ===== rtl/line_viewport_clip.sv =====
// Top level: clips lines against the configured viewport, fully pipelined.
//
//  channel   | direction | payload
//  ----------+-----------+-------------------------------------------------
//  cfg       | in        | i_cfg_addr register index, i_cfg_data value
//  s_axis    | in        | tdata: point_x, point_y, dir_x, dir_y
//  m_axis    | out       | tdata: end0_x/y, end1_x/y, label_x/y; tuser: visible
//
// One line per cycle while the output is not stalled; results pass through two
// 66-stage bit-per-cycle dividers in series (slope, then edge crossings).
// Reset clears the viewport to +-10.0, threshold to 1 and all valid bits.
// A stalled output register freezes the whole pipeline; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module line_viewport_clip (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [lvc_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  wire logic [lvc_pkg::CFG_DW-1:0]        i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // point_x, point_y, dir_x, dir_y
    input  wire logic [lvc_pkg::IN_W-1:0]          s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // end0_x, end0_y, end1_x, end1_y, label_x, label_y
    output logic [lvc_pkg::OUT_W-1:0]              m_axis_tdata,
    // visible
    output logic [0:0]                             m_axis_tuser
);

    localparam int QW  = lvc_pkg::QW;
    localparam int WW  = lvc_pkg::WW;
    localparam int FB  = lvc_pkg::FRAC_BITS;
    localparam int LAT = lvc_pkg::DIV_LAT;

    typedef struct packed {
        logic                 vld;
        logic                 zero;
        logic                 vert;
        logic signed [QW-1:0] px;
        logic signed [QW-1:0] py;
    } t_a;

    typedef struct packed {
        logic                 vld;
        logic                 zero;
        logic                 vert;
        logic                 horiz;
        logic signed [QW-1:0] px;
        logic signed [QW-1:0] py;
    } t_b;

    typedef struct packed {
        logic                 vld;
        logic                 zero;
        logic                 vert;
        logic                 horiz;
        logic signed [QW-1:0] px;
        logic signed [QW-1:0] py;
        logic signed [WW-1:0] yl;
        logic signed [WW-1:0] yr;
    } t_c;

    typedef struct packed {
        logic                 vld;
        logic                 vis;
        logic                 aneg;
        logic signed [QW-1:0] e0x;
        logic signed [QW-1:0] e0y;
        logic signed [QW-1:0] e1x;
        logic signed [QW-1:0] e1y;
        logic signed [QW-1:0] ax;
        logic signed [QW-1:0] ay;
    } t_e;

    function automatic logic signed [QW-1:0] sat_half(input logic signed [QW-1:0] v,
                                                      input logic neg);
        logic [QW:0] s;
        s = neg ? ({v[QW-1], v} - {1'b0, lvc_pkg::Q_HALF})
                : ({v[QW-1], v} + {1'b0, lvc_pkg::Q_HALF});
        if (s[QW] != s[QW-1]) begin
            return s[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end
        return $signed(s[QW-1:0]);
    endfunction

    // configuration
    logic signed [QW-1:0]              r_top, r_bottom, r_left, r_right;
    logic [lvc_pkg::NZL_W-1:0]         r_nzl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= $signed(lvc_pkg::VIEW_RST);
            r_bottom <= -$signed(lvc_pkg::VIEW_RST);
            r_left   <= -$signed(lvc_pkg::VIEW_RST);
            r_right  <= $signed(lvc_pkg::VIEW_RST);
            r_nzl    <= lvc_pkg::NZL_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                lvc_pkg::REG_TOP:    r_top    <= $signed(i_cfg_data[QW-1:0]);
                lvc_pkg::REG_BOTTOM: r_bottom <= $signed(i_cfg_data[QW-1:0]);
                lvc_pkg::REG_LEFT:   r_left   <= $signed(i_cfg_data[QW-1:0]);
                lvc_pkg::REG_RIGHT:  r_right  <= $signed(i_cfg_data[QW-1:0]);
                lvc_pkg::REG_NZL:    r_nzl    <= i_cfg_data[lvc_pkg::NZL_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [WW-1:0] w_top_w, w_bot_w;
    assign w_top_w = WW'(r_top);
    assign w_bot_w = WW'(r_bottom);

    // pipeline enable
    logic r_out_vld;
    logic w_en;
    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    // S1: capture and vertical test
    logic signed [QW-1:0]   w_px, w_py, w_dx, w_dy;
    logic signed [QW+3:0]   w_dx_w, w_ten;
    logic [QW+3:0]          w_ten_abs;
    logic                   w_vert, w_zero;

    assign w_px      = $signed(s_axis_tdata[QW-1:0]);
    assign w_py      = $signed(s_axis_tdata[2*QW-1:QW]);
    assign w_dx      = $signed(s_axis_tdata[3*QW-1:2*QW]);
    assign w_dy      = $signed(s_axis_tdata[4*QW-1:3*QW]);
    assign w_dx_w    = (QW+4)'(w_dx);
    assign w_ten     = (w_dx_w <<< 3) + (w_dx_w <<< 1);
    assign w_ten_abs = w_ten[QW+3] ? (QW+4)'(-w_ten) : (QW+4)'(w_ten);
    assign w_zero    = (w_dx == '0) && (w_dy == '0);
    assign w_vert    = (w_dx == '0) || (w_ten_abs < (QW+4)'(r_nzl));

    t_a                   r_s1;
    logic signed [QW-1:0] r_s1_dx, r_s1_dy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1.zero <= w_zero;
            r_s1.vert <= w_vert;
            r_s1.px   <= w_px;
            r_s1.py   <= w_py;
            r_s1_dx   <= w_dx;
            r_s1_dy   <= w_dy;
        end
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else if (w_en) begin
            r_s1.vld <= s_axis_tvalid;
        end
    end

    // slope divider and its delay line
    logic signed [WW-1:0] w_num_a;
    logic signed [QW-1:0] w_quo_a;
    assign w_num_a = WW'(r_s1_dy) <<< FB;

    lvc_div u_div_slope (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_num_a),
        .i_den (r_s1_dx),
        .o_quo (w_quo_a)
    );

    t_a r_dla [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_dla[k] <= '0;
            end
        end else if (w_en) begin
            r_dla[0] <= r_s1;
            for (int k = 1; k < LAT; k++) begin
                r_dla[k] <= r_dla[k-1];
            end
        end
    end

    // S2: horizontal test
    logic [QW:0] w_d_abs;
    logic        w_horiz;
    assign w_d_abs = w_quo_a[QW-1] ? (QW+1)'(-(QW+1)'(w_quo_a)) : (QW+1)'(w_quo_a);
    assign w_horiz = (w_quo_a == '0) || (w_d_abs < (QW+1)'(r_nzl));

    t_b                   r_s2, r_s3, r_s4;
    logic signed [QW-1:0] r_s2_d, r_s3_d, r_s4_d, r_s5_d;
    logic signed [WW-1:0] r_p0, r_p1, r_p2;
    logic signed [WW-1:0] r_b, r_q1, r_q2;
    logic signed [WW-1:0] r_num_t, r_num_b;
    t_c                   r_s5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
            r_s5 <= '0;
        end else if (w_en) begin
            r_s2.vld   <= r_dla[LAT-1].vld;
            r_s2.zero  <= r_dla[LAT-1].zero;
            r_s2.vert  <= r_dla[LAT-1].vert;
            r_s2.horiz <= w_horiz;
            r_s2.px    <= r_dla[LAT-1].px;
            r_s2.py    <= r_dla[LAT-1].py;
            r_s3       <= r_s2;
            r_s4       <= r_s3;
            r_s5.vld   <= r_s4.vld;
            r_s5.zero  <= r_s4.zero;
            r_s5.vert  <= r_s4.vert;
            r_s5.horiz <= r_s4.horiz;
            r_s5.px    <= r_s4.px;
            r_s5.py    <= r_s4.py;
            r_s5.yl    <= r_q1 + r_b;
            r_s5.yr    <= r_q2 + r_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_d  <= w_quo_a;
            // S3: products
            r_s3_d  <= r_s2_d;
            r_p0    <= r_s2_d * r_s2.px;
            r_p1    <= r_s2_d * r_left;
            r_p2    <= r_s2_d * r_right;
            // S4: intercept
            r_s4_d  <= r_s3_d;
            r_b     <= WW'(r_s3.py) - (r_p0 >>> FB);
            r_q1    <= r_p1 >>> FB;
            r_q2    <= r_p2 >>> FB;
            // S5: edge crossings, divider operands
            r_s5_d  <= r_s4_d;
            r_num_t <= (w_top_w - r_b) <<< FB;
            r_num_b <= (w_bot_w - r_b) <<< FB;
        end
    end

    // edge x dividers and delay line
    logic signed [QW-1:0] w_xt, w_xb;

    lvc_div u_div_top (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_num_t),
        .i_den (r_s5_d),
        .o_quo (w_xt)
    );

    lvc_div u_div_bot (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_num_b),
        .i_den (r_s5_d),
        .o_quo (w_xb)
    );

    t_c r_dlc [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_dlc[k] <= '0;
            end
        end else if (w_en) begin
            r_dlc[0] <= r_s5;
            for (int k = 1; k < LAT; k++) begin
                r_dlc[k] <= r_dlc[k-1];
            end
        end
    end

    // S6: hit tests and endpoint selection
    t_c                   w_c;
    logic                 w_hl, w_hr, w_ht, w_hb, w_tt, w_tb, w_vis_g;
    logic [1:0]           w_cnt;
    logic signed [QW-1:0] w_yl, w_yr;
    t_e                   n_e, r_e;

    assign w_c     = r_dlc[LAT-1];
    assign w_yl    = w_c.yl[QW-1:0];
    assign w_yr    = w_c.yr[QW-1:0];
    assign w_hl    = (w_c.yl >= w_bot_w) && (w_c.yl < w_top_w);
    assign w_hr    = (w_c.yr >= w_bot_w) && (w_c.yr < w_top_w);
    assign w_ht    = (w_xt >= r_left) && (w_xt < r_right);
    assign w_hb    = (w_xb >= r_left) && (w_xb < r_right);
    assign w_tt    = w_ht && !(w_hl && w_hr);
    assign w_cnt   = 2'(w_hl) + 2'(w_hr) + 2'(w_tt);
    assign w_tb    = w_hb && (w_cnt < 2'd2);
    assign w_vis_g = (w_cnt + 2'(w_tb)) == 2'd2;

    always_comb begin
        n_e     = '0;
        n_e.vld = w_c.vld;
        if (w_c.zero) begin
            n_e.vis = 1'b0;
        end else if (w_c.vert) begin
            n_e.vis = 1'b1;
            n_e.e0x = w_c.px;
            n_e.e0y = r_top;
            n_e.e1x = w_c.px;
            n_e.e1y = r_bottom;
            n_e.ax  = w_c.px;
            n_e.ay  = r_bottom;
        end else if (w_c.horiz) begin
            n_e.vis = 1'b1;
            n_e.e0x = r_left;
            n_e.e0y = w_c.py;
            n_e.e1x = r_right;
            n_e.e1y = w_c.py;
            n_e.ax  = r_left;
            n_e.ay  = w_c.py;
        end else begin
            n_e.vis = w_vis_g;
            if (w_hl) begin
                n_e.e0x = r_left;
                n_e.e0y = w_yl;
            end else if (w_hr) begin
                n_e.e0x = r_right;
                n_e.e0y = w_yr;
            end else if (w_tt) begin
                n_e.e0x = w_xt;
                n_e.e0y = r_top;
            end else begin
                n_e.e0x = w_xb;
                n_e.e0y = r_bottom;
            end
            if (w_hl && w_hr) begin
                n_e.e1x = r_right;
                n_e.e1y = w_yr;
            end else if ((w_hl || w_hr) && w_tt) begin
                n_e.e1x = w_xt;
                n_e.e1y = r_top;
            end else begin
                n_e.e1x = w_xb;
                n_e.e1y = r_bottom;
            end
            if (w_tb) begin
                n_e.ax = w_xb;
                n_e.ay = r_bottom;
            end else if (w_hl) begin
                n_e.ax = r_left;
                n_e.ay = w_yl;
            end else begin
                n_e.ax   = w_xt;
                n_e.ay   = r_top;
                n_e.aneg = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e <= '0;
        end else if (w_en) begin
            r_e <= n_e;
        end
    end

    // S7: anchor offset and output register
    logic [lvc_pkg::OUT_W-1:0] r_out_data;
    logic                      r_out_vis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_e.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_vis <= r_e.vis;
            if (r_e.vis) begin
                r_out_data <= {sat_half(r_e.ay, r_e.aneg), sat_half(r_e.ax, 1'b0),
                               r_e.e1y, r_e.e1x, r_e.e0y, r_e.e0x};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_vis;

endmodule

`default_nettype wire
